>>> rtl/core/pssm_window_scorer_core_assert.svh
// Assertion macros used by the scorer RTL.
`ifndef PSSM_WINDOW_SCORER_CORE_ASSERT_SVH
`define PSSM_WINDOW_SCORER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSSM_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSSM_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pssm_pkg.sv
`timescale 1ns / 1ps

package pssm_pkg;

  localparam int POS_W    = 5;
  localparam int BASE_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int SCORE_W  = 21;
  localparam int OFFSET_W = 16;
  localparam int LEN_W    = 6;

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd16;

  // Register map: one register, selected by paddr[2].
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_CHAR = 1'b1;

  typedef logic [2:0] code_t;

  localparam code_t CODE_A     = 3'd0;
  localparam code_t CODE_G     = 3'd1;
  localparam code_t CODE_C     = 3'd2;
  localparam code_t CODE_T     = 3'd3;
  localparam code_t CODE_OTHER = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

  // Controls broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic              adv;
    logic              shift;
    logic              clear;
    logic              load;
    logic [POS_W-1:0]  load_pos;
    logic [BASE_W-1:0] load_base;
  } cell_ctl_t;

  function automatic code_t base_code(input logic [CHAR_W-1:0] ch);
    code_t code;
    case (ch) inside
      CHAR_A_UP, CHAR_A_LO: code = CODE_A;
      CHAR_G_UP, CHAR_G_LO: code = CODE_G;
      CHAR_C_UP, CHAR_C_LO: code = CODE_C;
      CHAR_T_UP, CHAR_T_LO: code = CODE_T;
      default:              code = CODE_OTHER;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/core/pssm_window_scorer_core.sv
// Position weight matrix scorer over a sliding window of DNA characters.
// Items enter on the item channel (item_valid / item_stall). An item with
// mode 0 loads one signed weight for a window position and base; an item
// with mode 1 presents one ASCII character. Each character that completes
// a window of window_length characters gives one result on the result
// channel (result_valid / result_stall): the exact window score and the
// offset of the window's first character in the sequence.
// The chain of cells takes one item per clock while item_stall is low. A
// taken character shifts into the history, the cells register its lookups,
// and the registered adder tree of LEVELS levels, LEVELS being
// ceil(log2(MAX_WINDOW)) and at least 1, sums them into the result.
// window_length sits at APB byte address 0 and should be written only
// while no item is in flight.
// Reset clears the history, the fill count, the offset, all valid flags and
// sets window_length to 16; weights are undefined until loaded. While a
// result is held and result_stall is high, the whole pipeline holds and
// item_stall is raised; no item is lost.
`timescale 1ns / 1ps
`include "pssm_window_scorer_core_assert.svh"

module pssm_window_scorer_core #(
  parameter int MAX_WINDOW  = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [2:0]                    paddr,
  input  logic        [31:0]                   pwdata,
  output logic        [31:0]                   prdata,
  output logic                                 pready,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 mode,
  input  logic        [pssm_pkg::POS_W-1:0]    weight_position,
  input  logic        [pssm_pkg::BASE_W-1:0]   weight_base,
  input  logic signed [15:0]                   weight_value,
  input  logic        [pssm_pkg::CHAR_W-1:0]   base_char,
  input  logic                                 sequence_start,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [pssm_pkg::SCORE_W-1:0]  score,
  output logic        [pssm_pkg::OFFSET_W-1:0] window_start
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEVELS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W  = WEIGHT_BITS + LEVELS;

  logic [pssm_pkg::LEN_W-1:0]    window_length;
  logic [CNT_W-1:0]              eff_len;
  logic [CNT_W-1:0]              fill;
  logic [CNT_W-1:0]              fill_next;
  logic [pssm_pkg::OFFSET_W-1:0] offset;
  logic [pssm_pkg::OFFSET_W-1:0] offset_next;

  logic adv;
  logic accept;
  logic char_take;
  logic load_take;

  logic                          a_valid;
  logic [pssm_pkg::OFFSET_W-1:0] a_start;
  logic                          b_valid;
  logic [pssm_pkg::OFFSET_W-1:0] b_start;

  pssm_pkg::cell_ctl_t           ctl;
  pssm_pkg::code_t               new_code;
  pssm_pkg::code_t               hist [MAX_WINDOW];
  pssm_pkg::code_t               tap  [MAX_WINDOW];
  logic signed [WEIGHT_BITS-1:0] term [MAX_WINDOW];
  logic signed [WEIGHT_BITS-1:0] load_data;
  logic signed [SUM_W-1:0]       sum;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= pssm_pkg::LEN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == pssm_pkg::REG_WINDOW_LENGTH)) begin
      window_length <= pwdata[pssm_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == pssm_pkg::REG_WINDOW_LENGTH) begin
      prdata = 32'(window_length);
    end
  end

  always_comb begin
    if (window_length == '0) begin
      eff_len = CNT_W'(1);
    end else if ({1'b0, window_length} > 7'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(window_length);
    end
  end

  // Handshake: the pipeline moves whenever the output register can drain.
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;
  assign accept     = item_valid && adv;
  assign char_take  = accept && (mode == pssm_pkg::MODE_CHAR);
  assign load_take  = accept && (mode == pssm_pkg::MODE_LOAD);

  assign new_code  = pssm_pkg::base_code(base_char);
  assign load_data = WEIGHT_BITS'(weight_value);

  always_comb begin
    if (sequence_start) begin
      fill_next = CNT_W'(1);
    end else if (fill == CNT_W'(MAX_WINDOW)) begin
      fill_next = fill;
    end else begin
      fill_next = fill + CNT_W'(1);
    end
    offset_next = (sequence_start ? '0 : offset) + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      offset  <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      if (char_take) begin
        fill   <= fill_next;
        offset <= offset_next;
      end
      a_valid <= char_take && (fill_next >= eff_len);
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_start <= offset_next - pssm_pkg::OFFSET_W'(eff_len);
      b_start <= a_start;
    end
  end

  always_comb begin
    ctl.adv       = adv;
    ctl.shift     = char_take;
    ctl.clear     = sequence_start;
    ctl.load      = load_take;
    ctl.load_pos  = weight_position;
    ctl.load_base = weight_base;
  end

  // Window position k looks at the character held len-1-k places back.
  always_comb begin
    logic [CNT_W-1:0] tap_idx;
    tap_idx = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      tap[k] = pssm_pkg::CODE_OTHER;
      if (CNT_W'(k) < eff_len) begin
        tap_idx = eff_len - CNT_W'(k) - CNT_W'(1);
        tap[k]  = hist[tap_idx[IDX_W-1:0]];
      end
    end
  end

  genvar gk;
  generate
    for (gk = 0; gk < MAX_WINDOW; gk++) begin : g_cell
      pssm_pkg::code_t code_in;
      if (gk == 0) begin : g_head
        assign code_in = new_code;
      end else begin : g_link
        assign code_in = hist[gk-1];
      end

      pssm_cell #(
        .CELL_INDEX (gk),
        .WEIGHT_BITS(WEIGHT_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .load_data(load_data),
        .code_in  (code_in),
        .code_out (hist[gk]),
        .tap_code (tap[gk]),
        .term     (term[gk])
      );
    end
  endgenerate

  pssm_adder_tree #(
    .N     (MAX_WINDOW),
    .IN_W  (WEIGHT_BITS),
    .LEVELS(LEVELS),
    .SUM_W (SUM_W)
  ) u_tree (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (b_valid),
    .in_start (b_start),
    .term     (term),
    .out_valid(result_valid),
    .out_start(window_start),
    .out_sum  (sum)
  );

  generate
    if (SUM_W >= pssm_pkg::SCORE_W) begin : g_score_cut
      assign score = sum[pssm_pkg::SCORE_W-1:0];
    end else begin : g_score_ext
      assign score = pssm_pkg::SCORE_W'(sum);
    end
  endgenerate

  `PSSM_ASSERT_NEXT(a_restart_fill, clk, rst, char_take && sequence_start, fill == CNT_W'(1), "sequence start did not restart the fill count")
  `PSSM_ASSERT_NEXT(a_load_keeps_seq, clk, rst, load_take, (fill == $past(fill)) && (offset == $past(offset)), "weight load disturbed the sequence state")
  `PSSM_ASSERT_NEXT(a_offset_step, clk, rst, char_take && !sequence_start, offset == $past(offset) + 16'd1, "offset did not advance by one character")
  `PSSM_ASSERT_SAME(a_fill_bounded, clk, rst, 1'b1, fill <= CNT_W'(MAX_WINDOW), "fill count above window capacity")

endmodule

>>> rtl/core/pssm_cell.sv
`timescale 1ns / 1ps

// One link of the chain: holds one history code, passed on to the next cell
// on every character, and the four weights of one window position.
module pssm_cell #(
  parameter int CELL_INDEX  = 0,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pssm_pkg::cell_ctl_t           ctl,
  input  logic signed [WEIGHT_BITS-1:0] load_data,
  input  pssm_pkg::code_t               code_in,
  output pssm_pkg::code_t               code_out,
  input  pssm_pkg::code_t               tap_code,
  output logic signed [WEIGHT_BITS-1:0] term
);

  localparam logic [pssm_pkg::POS_W:0] CELL_POS = CELL_INDEX[pssm_pkg::POS_W:0];

  logic signed [WEIGHT_BITS-1:0] weight [4];
  logic                          hit;

  assign hit = ctl.load && ({1'b0, ctl.load_pos} == CELL_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_out <= pssm_pkg::CODE_OTHER;
    end else if (ctl.shift) begin
      // A new sequence empties the history behind the first character.
      if (ctl.clear && (CELL_INDEX != 0)) begin
        code_out <= pssm_pkg::CODE_OTHER;
      end else begin
        code_out <= code_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      weight[ctl.load_base] <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      if (tap_code == pssm_pkg::CODE_OTHER) begin
        term <= '0;
      end else begin
        term <= weight[tap_code[1:0]];
      end
    end
  end

endmodule

>>> rtl/core/pssm_adder_tree.sv
`timescale 1ns / 1ps

// Registered binary adder tree, a register at each level, with the valid flag and
// the window offset carried alongside.
module pssm_adder_tree #(
  parameter int N      = 32,
  parameter int IN_W   = 16,
  parameter int LEVELS = 5,
  parameter int SUM_W  = 21
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic        [pssm_pkg::OFFSET_W-1:0] in_start,
  input  logic signed [IN_W-1:0]               term [N],
  output logic                                 out_valid,
  output logic        [pssm_pkg::OFFSET_W-1:0] out_start,
  output logic signed [SUM_W-1:0]              out_sum
);

  localparam int P = 1 << LEVELS;

  logic signed [SUM_W-1:0]              leaf [P];
  logic signed [SUM_W-1:0]              node [1:P-1];
  logic                                 vld  [LEVELS];
  logic        [pssm_pkg::OFFSET_W-1:0] start [LEVELS];

  genvar gi;
  generate
    for (gi = 0; gi < P; gi++) begin : g_leaf
      if (gi < N) begin : g_used
        assign leaf[gi] = SUM_W'(term[gi]);
      end else begin : g_pad
        assign leaf[gi] = '0;
      end
    end

    // Heap order: node 1 is the root, children of node n are 2n and 2n+1.
    for (gi = 1; gi < P; gi++) begin : g_node
      if (2 * gi < P) begin : g_inner
        always_ff @(posedge clk) begin
          if (adv) begin
            node[gi] <= node[2*gi] + node[2*gi+1];
          end
        end
      end else begin : g_bottom
        always_ff @(posedge clk) begin
          if (adv) begin
            node[gi] <= leaf[2*gi-P] + leaf[2*gi+1-P];
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LEVELS; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      start[0] <= in_start;
      for (int i = 1; i < LEVELS; i++) begin
        start[i] <= start[i-1];
      end
    end
  end

  assign out_valid = vld[LEVELS-1];
  assign out_start = start[LEVELS-1];
  assign out_sum   = node[1];

endmodule

>>> tb/pssm_window_scorer_checker.sv
`timescale 1ns / 1ps

module pssm_window_scorer_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [2:0]                    paddr,
  input  logic        [31:0]                   pwdata,
  input  logic                                 pready,
  input  logic                                 item_valid,
  input  logic                                 item_stall,
  input  logic                                 mode,
  input  logic        [pssm_pkg::POS_W-1:0]    weight_position,
  input  logic        [pssm_pkg::BASE_W-1:0]   weight_base,
  input  logic signed [15:0]                   weight_value,
  input  logic        [pssm_pkg::CHAR_W-1:0]   base_char,
  input  logic                                 sequence_start,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  logic signed [pssm_pkg::SCORE_W-1:0]  score,
  input  logic        [pssm_pkg::OFFSET_W-1:0] window_start,
  output int                                   mismatch_count,
  output int                                   pending_results
);
  import pssm_pkg::*;

  localparam int WINDOW_SLOTS = 32;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [OFFSET_W-1:0]       start;
  } window_score_t;

  logic signed [15:0]  weight_mem [WINDOW_SLOTS][4];
  code_t               recent [WINDOW_SLOTS];
  int unsigned         held_count;
  logic [OFFSET_W-1:0] next_offset;
  logic [LEN_W-1:0]    length_reg;
  window_score_t       expected_scores [$];
  int                  errors;

  function automatic code_t char_column(input logic [CHAR_W-1:0] ch);
    if (ch == CHAR_A_UP || ch == CHAR_A_LO) return CODE_A;
    if (ch == CHAR_G_UP || ch == CHAR_G_LO) return CODE_G;
    if (ch == CHAR_C_UP || ch == CHAR_C_LO) return CODE_C;
    if (ch == CHAR_T_UP || ch == CHAR_T_LO) return CODE_T;
    return CODE_OTHER;
  endfunction

  task automatic take_char(input logic [CHAR_W-1:0] ch, input logic restart);
    int                        span;
    logic signed [SCORE_W-1:0] sum;
    window_score_t             entry;
    code_t                     c;
    if (restart) begin
      foreach (recent[k]) recent[k] = CODE_OTHER;
      held_count = 0;
      next_offset = '0;
    end
    for (int k = WINDOW_SLOTS - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = char_column(ch);
    if (held_count < WINDOW_SLOTS) held_count++;
    next_offset++;
    // Out-of-range lengths are clamped into 1..WINDOW_SLOTS.
    if (length_reg == 0) span = 1;
    else if (length_reg > WINDOW_SLOTS) span = WINDOW_SLOTS;
    else span = length_reg;
    if (held_count >= span) begin
      sum = '0;
      // Window position 0 is the oldest character held in the window.
      for (int k = 0; k < span; k++) begin
        c = recent[span-1-k];
        if (c != CODE_OTHER) sum += weight_mem[k][c[BASE_W-1:0]];
      end
      entry.score = sum;
      entry.start = next_offset - span[OFFSET_W-1:0];
      expected_scores.push_back(entry);
    end
  endtask

  always @(posedge clk) begin
    window_score_t want;
    if (rst) begin
      foreach (recent[k]) recent[k] = CODE_OTHER;
      held_count = 0;
      next_offset = '0;
      length_reg = LEN_RESET;
      expected_scores.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_scores.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got score %0d window_start %0d",
                   $time, score, window_start);
        end else begin
          want = expected_scores.pop_front();
          if (score !== want.score) begin
            errors++;
            $display("%0t: score expected %0d, got %0d", $time, want.score, score);
          end
          if (window_start !== want.start) begin
            errors++;
            $display("%0t: window_start expected %0d, got %0d",
                     $time, want.start, window_start);
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_LENGTH)
        length_reg = pwdata[LEN_W-1:0];
      if (item_valid && !item_stall) begin
        if (mode == MODE_LOAD) weight_mem[weight_position][weight_base] = weight_value;
        else take_char(base_char, sequence_start);
      end
    end
    mismatch_count <= errors;
    pending_results <= expected_scores.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pssm_pkg::*;

  localparam logic [2:0] ADDR_WINDOW_LENGTH = {REG_WINDOW_LENGTH, 2'b00};
  localparam logic [2:0] ADDR_SPARE         = {~REG_WINDOW_LENGTH, 2'b00};
  localparam logic signed [15:0] WEIGHT_MAX = 16'sh7fff;
  localparam logic signed [15:0] WEIGHT_MIN = 16'sh8000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_RUN      = 300;
  localparam int BLOCK_ITEMS   = 130;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [2:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  logic                       mode = MODE_CHAR;
  logic [POS_W-1:0]           weight_position = '0;
  logic [BASE_W-1:0]          weight_base = '0;
  logic signed [15:0]         weight_value = '0;
  logic [CHAR_W-1:0]          base_char = '0;
  logic                       sequence_start = 1'b0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic signed [SCORE_W-1:0]  score;
  logic [OFFSET_W-1:0]        window_start;

  int mismatch_count;
  int pending_results;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pssm_window_scorer_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .mode(mode), .weight_position(weight_position), .weight_base(weight_base),
    .weight_value(weight_value), .base_char(base_char), .sequence_start(sequence_start),
    .result_valid(result_valid), .result_stall(result_stall),
    .score(score), .window_start(window_start)
  );

  pssm_window_scorer_checker score_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .item_valid(item_valid), .item_stall(item_stall),
    .mode(mode), .weight_position(weight_position), .weight_base(weight_base),
    .weight_value(weight_value), .base_char(base_char), .sequence_start(sequence_start),
    .result_valid(result_valid), .result_stall(result_stall),
    .score(score), .window_start(window_start),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  // Result receiver. A requested hold-off keeps result_stall high for a long
  // stretch so the pipeline fills and pushes back on the item channel.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic m, input logic [POS_W-1:0] pos,
                           input logic [BASE_W-1:0] col, input logic signed [15:0] val,
                           input logic [CHAR_W-1:0] ch, input logic restart);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid      <= 1'b1;
    mode            <= m;
    weight_position <= pos;
    weight_base     <= col;
    weight_value    <= val;
    base_char       <= ch;
    sequence_start  <= restart;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // The weight fields of a character item are ignored, so they carry noise.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic restart);
    send_item(MODE_CHAR, POS_W'($urandom), BASE_W'($urandom), 16'($urandom), ch, restart);
  endtask

  task automatic send_weight(input logic [POS_W-1:0] pos, input logic [BASE_W-1:0] col,
                             input logic signed [15:0] val);
    send_item(MODE_LOAD, pos, col, val, CHAR_W'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Characters that give no result may still be in the pipeline when the
  // last expected result arrives, so a settling wait follows.
  task automatic wait_idle;
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    logic [31:0] data;
    data = $urandom;
    data[LEN_W-1:0] = len;
    wait_idle();
    write_reg(ADDR_WINDOW_LENGTH, data);
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(9))
      0: return CHAR_A_UP;
      1: return CHAR_A_LO;
      2: return CHAR_G_UP;
      3: return CHAR_G_LO;
      4: return CHAR_C_UP;
      5: return CHAR_C_LO;
      6: return CHAR_T_UP;
      7: return CHAR_T_LO;
      default: return CHAR_W'($urandom);
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_length(input int slot);
    case (slot % 6)
      0: return LEN_W'($urandom_range(1, 32));
      1: return LEN_W'(32);
      2: return LEN_W'(1);
      3: return LEN_W'(0);
      4: return LEN_W'($urandom_range(33, 63));
      default: return LEN_W'($urandom_range(2, 31));
    endcase
  endfunction

  // Mostly sequences that open with a start flag and run long enough to fill
  // the window, with weight reloads and stray restarts mixed in. About one
  // sequence in ten continues the previous one instead of restarting.
  task automatic run_sequences(input int count);
    int left;
    int seq_len;
    left = count;
    while (left > 0) begin
      seq_len = $urandom_range(1, 70);
      for (int k = 0; k < seq_len && left > 0; k++) begin
        if ($urandom_range(99) < 6)
          send_weight(POS_W'($urandom), BASE_W'($urandom), 16'($urandom));
        else if (k == 0)
          send_char(pick_char(), $urandom_range(9) != 0);
        else
          send_char(pick_char(), $urandom_range(99) == 0);
        left--;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole table first so no unwritten weight is ever read. Column
    // A holds the largest weight and column G the smallest.
    for (int p = 0; p < 32; p++) begin
      for (int b = 0; b < 4; b++) begin
        if (b == CODE_A) send_weight(POS_W'(p), BASE_W'(b), WEIGHT_MAX);
        else if (b == CODE_G) send_weight(POS_W'(p), BASE_W'(b), WEIGHT_MIN);
        else send_weight(POS_W'(p), BASE_W'(b), 16'($urandom));
      end
    end

    // Full-length windows of all-A and all-G give the extreme scores.
    set_length(LEN_W'(32));
    send_char(CHAR_A_UP, 1'b1);
    repeat (31) send_char(CHAR_A_UP, 1'b0);
    repeat (32) send_char(CHAR_G_LO, 1'b0);

    set_length(LEN_W'(1));
    send_char(CHAR_A_LO, 1'b1);
    send_char(CHAR_G_UP, 1'b0);
    send_char(CHAR_C_UP, 1'b0);
    send_char(CHAR_C_LO, 1'b0);
    send_char(CHAR_T_LO, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char("N", 1'b0);
    send_char(CHAR_T_UP, 1'b1);
    send_item(MODE_LOAD, '0, CODE_C[BASE_W-1:0], WEIGHT_MIN, CHAR_A_UP, 1'b1);
    send_char(CHAR_C_UP, 1'b0);

    set_length(LEN_W'(0));
    send_char(CHAR_G_UP, 1'b0);
    wait_idle();
    write_reg(ADDR_SPARE, 32'd5);
    send_char(CHAR_A_UP, 1'b0);

    // The held characters stay in place across the length change.
    set_length(LEN_W'(63));
    send_char(CHAR_T_UP, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 18;
          rx_idle_pct = 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct = 18;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        set_length(pick_length(phase * 4 + blk));
        run_sequences(BLOCK_ITEMS);
      end
    end

    // One long sequence closes the run and starts with a long receiver
    // hold-off while items keep coming.
    set_length(LEN_W'(1));
    hold_req = 1'b1;
    send_char(pick_char(), 1'b1);
    repeat (TAIL_RUN - 1) send_char(pick_char(), 1'b0);

    wait_idle();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
